// ===== rtl/css_lex_pkg.sv =====
// Shared types and constants for the CSS subset lexer.
package css_lex_pkg;

    localparam logic [3:0] KIND_LBRACE = 4'd0;
    localparam logic [3:0] KIND_RBRACE = 4'd1;
    localparam logic [3:0] KIND_COLON  = 4'd2;
    localparam logic [3:0] KIND_SEMI   = 4'd3;
    localparam logic [3:0] KIND_DOT    = 4'd4;
    localparam logic [3:0] KIND_HASH   = 4'd5;
    localparam logic [3:0] KIND_IDENT  = 4'd6;
    localparam logic [3:0] KIND_NUMBER = 4'd7;
    localparam logic [3:0] KIND_END    = 4'd8;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_marker;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] token_offset;
        logic [15:0] token_length;
        logic        run_last;
    } t_out_item;

    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  item0;
        t_out_item  item1;
    } t_lex_res;

endpackage

// ===== rtl/css_lex_core.sv =====
// Lexer state and per-byte classification; produces up to two tokens per byte.
module css_lex_core #(
    parameter int POS_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  css_lex_pkg::t_in_item i_item,
    output css_lex_pkg::t_lex_res o_res
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_IDENT  = 2'd1,
        ST_NUMBER = 2'd2
    } t_mode;

    localparam int LW = (POS_BITS > 16) ? POS_BITS : 16;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    t_mode               r_mode, n_mode;
    logic                r_dot, n_dot;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [POS_BITS-1:0] r_start, n_start;

    logic [7:0]          c;
    logic                is_letter, is_digit, ident_start, ident_cont;
    logic                open_id, open_num, consumed;
    logic                single_hit, have_close, have_single;
    logic [3:0]          single_kind;
    logic [POS_BITS-1:0] len_full;
    logic [LW-1:0]       len_ext, start_ext, pos_ext;
    logic [15:0]         len_sat;
    css_lex_pkg::t_out_item close_item, single_item;

    always_comb begin
        c           = i_item.char_byte;
        is_letter   = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        is_digit    = (c >= "0" && c <= "9");
        ident_start = is_letter || c == "_" || c == "-";
        ident_cont  = ident_start || is_digit;
        open_id     = (r_mode == ST_IDENT);
        open_num    = (r_mode == ST_NUMBER);

        len_full  = (r_pos >= r_start) ? r_pos - r_start : '0;
        len_ext   = LW'(len_full);
        start_ext = LW'(r_start);
        pos_ext   = LW'(r_pos);
        len_sat   = (len_ext > LW'(16'hFFFF)) ? 16'hFFFF : len_ext[15:0];

        close_item.token_kind   = open_id ? css_lex_pkg::KIND_IDENT : css_lex_pkg::KIND_NUMBER;
        close_item.token_offset = start_ext[15:0];
        close_item.token_length = len_sat;
        close_item.run_last     = 1'b0;

        single_hit  = 1'b1;
        single_kind = css_lex_pkg::KIND_LBRACE;
        unique case (c)
            "{":     single_kind = css_lex_pkg::KIND_LBRACE;
            "}":     single_kind = css_lex_pkg::KIND_RBRACE;
            ":":     single_kind = css_lex_pkg::KIND_COLON;
            ";":     single_kind = css_lex_pkg::KIND_SEMI;
            ".":     single_kind = css_lex_pkg::KIND_DOT;
            "#":     single_kind = css_lex_pkg::KIND_HASH;
            default: single_hit  = 1'b0;
        endcase

        single_item.token_kind   = single_kind;
        single_item.token_offset = pos_ext[15:0];
        single_item.token_length = 16'd1;
        single_item.run_last     = 1'b1;

        n_mode      = r_mode;
        n_dot       = r_dot;
        n_start     = r_start;
        n_pos       = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
        have_close  = 1'b0;
        have_single = 1'b0;
        consumed    = 1'b0;

        if (i_item.end_marker) begin
            have_close               = open_id || open_num;
            have_single              = 1'b1;
            single_item.token_kind   = css_lex_pkg::KIND_END;
            single_item.token_length = 16'd0;
            n_mode                   = ST_IDLE;
            n_dot                    = 1'b0;
            n_pos                    = '0;
            n_start                  = '0;
        end else begin
            consumed = (open_id && ident_cont) ||
                       (open_num && (is_digit || (c == "." && !r_dot)));
            if (consumed) begin
                if (open_num && c == ".") begin
                    n_dot = 1'b1;
                end
            end else begin
                have_close  = open_id || open_num;
                have_single = single_hit;
                n_dot       = 1'b0;
                if (ident_start) begin
                    n_mode  = ST_IDENT;
                    n_start = r_pos;
                end else if (is_digit) begin
                    n_mode  = ST_NUMBER;
                    n_start = r_pos;
                end else begin
                    n_mode = ST_IDLE;
                end
            end
        end

        o_res.cnt            = {1'b0, have_close} + {1'b0, have_single};
        o_res.item0          = have_close ? close_item : single_item;
        o_res.item0.run_last = !(have_close && have_single);
        o_res.item1          = single_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ST_IDLE;
            r_dot   <= 1'b0;
            r_pos   <= '0;
            r_start <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_dot   <= n_dot;
            r_pos   <= n_pos;
            r_start <= n_start;
        end
    end

endmodule

// ===== rtl/css_lex_outq.sv =====
// Four-entry token queue that takes up to two tokens a cycle and releases one.
module css_lex_outq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  css_lex_pkg::t_lex_res  i_res,
    input  logic                   i_wr,
    input  logic                   i_stall,
    output logic                   o_space,
    output logic                   o_valid,
    output css_lex_pkg::t_out_item o_item
);

    css_lex_pkg::t_out_item r_mem [css_lex_pkg::OQ_DEPTH];
    logic [css_lex_pkg::OQ_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [css_lex_pkg::OQ_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [css_lex_pkg::OQ_AW:0]   r_count, n_count;
    logic [css_lex_pkg::OQ_AW-1:0] wr_ptr1;
    logic [1:0]                    wr_cnt;
    logic                          pop;

    always_comb begin
        wr_cnt   = i_wr ? i_res.cnt : 2'd0;
        pop      = o_valid && !i_stall;
        wr_ptr1  = r_wr_ptr + 1'b1;
        n_wr_ptr = r_wr_ptr + css_lex_pkg::OQ_AW'(wr_cnt);
        n_rd_ptr = r_rd_ptr + css_lex_pkg::OQ_AW'(pop);
        n_count  = r_count + (css_lex_pkg::OQ_AW + 1)'(wr_cnt)
                           - (css_lex_pkg::OQ_AW + 1)'(pop);
    end

    assign o_space = r_count <= (css_lex_pkg::OQ_AW + 1)'(css_lex_pkg::OQ_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res.item0;
        end
        if (wr_cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_res.item1;
        end
    end

endmodule

// ===== rtl/css_subset_lexer.sv =====
// Streaming CSS subset lexer: bytes in, tokens (kind, offset, length) out.
// One byte is taken per cycle into an input register unless o_stall holds it there, lexed
// from that register once the queue has space, and its zero, one or two tokens go into a
// four-entry queue that drives the output port. The output port moves one token per cycle
// while i_stall is low, so input runs at one byte per cycle while each byte yields at most
// one token; a byte that both closes a token and emits another needs two output slots, and
// the queue absorbs short bursts of those. No clearing pass after reset.
module css_subset_lexer #(
    parameter int POS_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  css_lex_pkg::t_in_item  i_item,
    output logic                   o_stall,
    output logic                   o_valid,
    output css_lex_pkg::t_out_item o_item,
    input  logic                   i_stall
);

    logic                  r_in_valid;
    css_lex_pkg::t_in_item r_in;
    css_lex_pkg::t_lex_res res;
    logic                  space;
    logic                  step;

    assign step    = r_in_valid && space;
    assign o_stall = r_in_valid && !space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_item;
        end
    end

    css_lex_core #(
        .POS_BITS(POS_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .o_res   (res)
    );

    css_lex_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .i_wr    (step),
        .i_stall (i_stall),
        .o_space (space),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

endmodule

// ===== rtl/css_lex_checker.sv =====
// Port-level assertions for the CSS subset lexer, bound to the top level.
module css_lex_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_valid,
    input logic                   i_stall,
    input css_lex_pkg::t_out_item o_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("output transaction changed while stalled");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.token_kind <= css_lex_pkg::KIND_END)
        else $error("token kind out of range");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.token_kind == css_lex_pkg::KIND_END |->
            o_item.token_length == 16'd0 && o_item.run_last)
        else $error("end token malformed");

    a_single_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.token_kind <= css_lex_pkg::KIND_HASH |->
            o_item.token_length == 16'd1 && o_item.run_last)
        else $error("single-byte token malformed");

endmodule

bind css_subset_lexer css_lex_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for css_subset_lexer: random and directed byte streams vs. a token predictor.
`timescale 1ns / 1ps

localparam int POS_BITS = 16;

localparam logic [7:0] CH_LBRACE = "{";
localparam logic [7:0] CH_RBRACE = "}";
localparam logic [7:0] CH_COLON  = ":";
localparam logic [7:0] CH_SEMI   = ";";
localparam logic [7:0] CH_DOT    = ".";
localparam logic [7:0] CH_HASH   = "#";
localparam logic [7:0] CH_DASH   = "-";
localparam logic [7:0] CH_UNDER  = "_";
localparam logic [7:0] CH_SPACE  = 8'h20;
localparam logic [7:0] CH_TAB    = 8'h09;
localparam logic [7:0] CH_NL     = 8'h0A;

typedef enum logic [1:0] {
    LM_IDLE   = 2'd0,
    LM_IDENT  = 2'd1,
    LM_NUMBER = 2'd2
} t_lex_mode;

class token_scoreboard;
    css_lex_pkg::t_out_item expected_tokens[$];
    t_lex_mode           mode;
    bit                  in_fraction;
    logic [POS_BITS-1:0] next_pos;
    logic [POS_BITS-1:0] tok_start;
    int                  n_errors;

    function new();
        n_errors = 0;
        reset_state();
    endfunction

    function void reset_state();
        mode        = LM_IDLE;
        in_fraction = 1'b0;
        next_pos    = '0;
        tok_start   = '0;
    endfunction

    function int pending();
        return expected_tokens.size();
    endfunction

    function bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function void push_token(logic [3:0] kind, logic [POS_BITS-1:0] off, longint len);
        css_lex_pkg::t_out_item tok;
        tok.token_kind   = kind;
        tok.token_offset = 16'(off);
        tok.token_length = (len > 65535) ? 16'hFFFF : 16'(len);
        tok.run_last     = 1'b0;
        expected_tokens = {expected_tokens, tok};
    endfunction

    function int close_open();
        int     n;
        longint len;
        n = 0;
        if (mode == LM_IDENT || mode == LM_NUMBER) begin
            len = (next_pos >= tok_start) ? longint'(next_pos) - longint'(tok_start) : 0;
            push_token((mode == LM_IDENT) ? css_lex_pkg::KIND_IDENT : css_lex_pkg::KIND_NUMBER,
                       tok_start, len);
            n = 1;
        end
        mode        = LM_IDLE;
        in_fraction = 1'b0;
        return n;
    endfunction

    function int start_byte(logic [7:0] c);
        logic [3:0] kind;
        bit         single;
        single = 1'b1;
        case (c)
            CH_LBRACE: kind = css_lex_pkg::KIND_LBRACE;
            CH_RBRACE: kind = css_lex_pkg::KIND_RBRACE;
            CH_COLON:  kind = css_lex_pkg::KIND_COLON;
            CH_SEMI:   kind = css_lex_pkg::KIND_SEMI;
            CH_DOT:    kind = css_lex_pkg::KIND_DOT;
            CH_HASH:   kind = css_lex_pkg::KIND_HASH;
            default: begin
                kind   = css_lex_pkg::KIND_END;
                single = 1'b0;
            end
        endcase
        if (single) begin
            push_token(kind, next_pos, 1);
            return 1;
        end
        if (is_letter(c) || c == CH_UNDER || c == CH_DASH) begin
            mode      = LM_IDENT;
            tok_start = next_pos;
        end else if (is_digit(c)) begin
            mode        = LM_NUMBER;
            in_fraction = 1'b0;
            tok_start   = next_pos;
        end
        return 0;
    endfunction

    function void note_input(css_lex_pkg::t_in_item it);
        int        k;
        bit        taken;
        css_lex_pkg::t_out_item tail;
        k     = 0;
        taken = 1'b0;
        if (it.end_marker) begin
            k += close_open();
            push_token(css_lex_pkg::KIND_END, next_pos, 0);
            k++;
            reset_state();
        end else begin
            if (mode == LM_IDENT) begin
                taken = is_letter(it.char_byte) || is_digit(it.char_byte) ||
                        it.char_byte == CH_DASH || it.char_byte == CH_UNDER;
            end else if (mode == LM_NUMBER) begin
                if (is_digit(it.char_byte)) begin
                    taken = 1'b1;
                end else if (it.char_byte == CH_DOT && !in_fraction) begin
                    in_fraction = 1'b1;
                    taken       = 1'b1;
                end
            end
            if (!taken) begin
                k += close_open();
                k += start_byte(it.char_byte);
            end
            if (next_pos != '1) next_pos++;
        end
        if (k > 0) begin
            tail = expected_tokens.pop_back();
            tail.run_last = 1'b1;
            expected_tokens = {expected_tokens, tail};
        end
    endfunction

    function void check_result(css_lex_pkg::t_out_item got);
        css_lex_pkg::t_out_item want;
        if (expected_tokens.size() == 0) begin
            $error("unexpected token: kind %0d offset %0d length %0d",
                   got.token_kind, got.token_offset, got.token_length);
            n_errors++;
            return;
        end
        want = expected_tokens.pop_front();
        if (got.token_kind !== want.token_kind) begin
            $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
            n_errors++;
        end
        if (got.token_offset !== want.token_offset) begin
            $error("token_offset: expected %0d, got %0d", want.token_offset, got.token_offset);
            n_errors++;
        end
        if (got.token_length !== want.token_length) begin
            $error("token_length: expected %0d, got %0d", want.token_length, got.token_length);
            n_errors++;
        end
        if (got.run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
            n_errors++;
        end
    endfunction
endclass

module testbench;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    css_lex_pkg::t_in_item  i_item  = '0;
    logic      i_stall = 1'b0;
    logic      o_stall;
    logic      o_valid;
    css_lex_pkg::t_out_item o_item;

    int src_idle_pct   = 17;
    int sink_stall_pct = 53;
    int n_sent         = 0;

    token_scoreboard scb = new();

    css_subset_lexer #(
        .POS_BITS(POS_BITS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_item (i_item),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .o_item (o_item),
        .i_stall(i_stall)
    );

    always begin
        #1;
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) scb.check_result(o_item);
        i_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    initial begin
        #4_000_000;
        $display("css_subset_lexer test failed");
        $finish;
    end

    task automatic send_item(input css_lex_pkg::t_in_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        scb.note_input(it);
        n_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        css_lex_pkg::t_in_item it;
        it.char_byte  = b;
        it.end_marker = 1'b0;
        send_item(it);
    endtask

    task automatic send_end(input logic [7:0] b);
        css_lex_pkg::t_in_item it;
        it.char_byte  = b;
        it.end_marker = 1'b1;
        send_item(it);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (scb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_ident_char(input bit first);
        int r;
        r = $urandom_range(first ? 53 : 63);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r == 52) return CH_DASH;
        if (r == 53) return CH_UNDER;
        return 8'("0" + r - 54);
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'("0" + $urandom_range(9));
    endfunction

    task automatic send_fragment();
        int r;
        r = $urandom_range(99);
        if (r < 25) begin
            send_byte(pick_ident_char(1'b1));
            repeat ($urandom_range(12)) send_byte(pick_ident_char(1'b0));
        end else if (r < 45) begin
            repeat ($urandom_range(5, 1)) send_byte(pick_digit());
            if ($urandom_range(1)) begin
                send_byte(CH_DOT);
                repeat ($urandom_range(4)) send_byte(pick_digit());
                if ($urandom_range(99) < 15) begin
                    send_byte(CH_DOT);
                    repeat ($urandom_range(3)) send_byte(pick_digit());
                end
            end
        end else if (r < 65) begin
            case ($urandom_range(5))
                0: send_byte(CH_LBRACE);
                1: send_byte(CH_RBRACE);
                2: send_byte(CH_COLON);
                3: send_byte(CH_SEMI);
                4: send_byte(CH_DOT);
                default: send_byte(CH_HASH);
            endcase
        end else if (r < 80) begin
            case ($urandom_range(2))
                0: send_byte(CH_SPACE);
                1: send_byte(CH_TAB);
                default: send_byte(CH_NL);
            endcase
        end else if (r < 96) begin
            send_byte(8'($urandom_range(255)));
        end else begin
            send_end(8'($urandom_range(255)));
        end
    endtask

    task automatic run_random(input int n);
        int target;
        target = n_sent + n;
        while (n_sent < target) send_fragment();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every single-byte token, ident/number edges, second dot, unknown bytes
        send_text("{}:;.#");
        send_text("aZ_-9:");
        send_text("0.5.7 ");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_text("_x");
        send_end(8'hFF);
        send_text("42.");
        send_end(8'h00);

        run_random(430);
        wait_drained();

        src_idle_pct   = 53;
        sink_stall_pct = 17;
        run_random(215);
        wait_drained();
        run_random(215);
        wait_drained();

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // fresh stream right after an end marker, then back-to-back traffic
        send_end(8'h00);
        send_text("ab;7");
        send_end(8'h3B);
        run_random(430);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (scb.n_errors == 0 && scb.pending() == 0) begin
            $display("css_subset_lexer test passed");
        end else begin
            $display("css_subset_lexer test failed");
        end
        $finish;
    end

endmodule
